// ===== hw/rtl/terq_pkg.sv =====
package terq_pkg;

    // Default number of queue slots
    localparam int QUEUE_DEPTH_DEF = 16;

    // Most events handed out by one release word
    localparam int MAX_RELEASE = 16;
    localparam int REL_CNT_W   = $clog2(MAX_RELEASE + 1);

    localparam logic [30:0] TIME_MAX   = 31'h7FFF_FFFF;
    localparam logic [15:0] TICK_RESET = 16'd10;

    // Input word modes
    localparam logic [1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [1:0] MODE_ADVANCE  = 2'd1;
    localparam logic [1:0] MODE_RELEASE  = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_SCHEDULED = 3'd0;
    localparam logic [2:0] STAT_DROPPED   = 3'd1;
    localparam logic [2:0] STAT_RELEASED  = 3'd2;
    localparam logic [2:0] STAT_NONE_DUE  = 3'd3;
    localparam logic [2:0] STAT_ADVANCED  = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [30:0] deadline_ms;
        logic [31:0] sequence_in;
        logic [7:0]  event_kind;
        logic [15:0] source_id;
        logic [15:0] target_id;
        logic [31:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] out_deadline_ms;
        logic [31:0] out_sequence;
        logic [7:0]  out_kind;
        logic [15:0] out_source_id;
        logic [15:0] out_target_id;
        logic [31:0] out_payload;
        logic [30:0] now_ms;
        logic        last;
    } out_word_t;

    // One queue slot; {deadline, seq} is the sort key
    typedef struct packed {
        logic [30:0] deadline;
        logic [31:0] seq;
        logic [7:0]  kind;
        logic [15:0] source;
        logic [15:0] target;
        logic [31:0] data;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PICK,
        S_COPY_RD,
        S_COPY_WR,
        S_NEXT,
        S_FINAL
    } state_t;

    function automatic out_word_t make_result(input logic [2:0]  status,
                                              input entry_t      ent,
                                              input logic [30:0] now,
                                              input logic        last);
        out_word_t r;
        r.status          = status;
        r.out_deadline_ms = ent.deadline;
        r.out_sequence    = ent.seq;
        r.out_kind        = ent.kind;
        r.out_source_id   = ent.source;
        r.out_target_id   = ent.target;
        r.out_payload     = ent.data;
        r.now_ms          = now;
        r.last            = last;
        return r;
    endfunction

endpackage

// ===== hw/rtl/timed_event_release_queue.sv =====
// Channel   Direction  Ports                          Contents
// s_        in         s_valid s_ready s_word         schedule / advance / release word
// m_        out        m_valid m_ready m_word         result word, last marks final
// cfg_      in         cfg_wr_en cfg_wr_data          tick length in ms
//
// Schedule and advance: the result is registered on acceptance; s_ready
// returns once it is taken, so a new word waits until the result drains.
// Release: a scan reads every stored slot through the single memory read port
// (read, then compare), then a pick state and a copy loop (read, write per moved
// slot) close the gap behind the released slot, and a restart state follows;
// this repeats per released event, up to 16 events per word.
// s_ready is high only in idle with the output register empty.
// Reset (synchronous, aresetn low) empties the queue, time 0, sequence 1, tick 10.
module timed_event_release_queue
    import terq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    // Slot memory, kept in insertion order, first used_reg entries live
    entry_t slot_mem [QUEUE_DEPTH];

    state_t                 state_reg, state_next;
    logic [CntW-1:0]        used_reg, used_next;
    logic [IdxW-1:0]        idx_reg, idx_next;
    logic [IdxW-1:0]        best_idx_reg, best_idx_next;
    logic                   best_found_reg, best_found_next;
    entry_t                 best_reg, best_next;
    entry_t                 pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [REL_CNT_W-1:0]   rel_cnt_reg, rel_cnt_next;
    logic [30:0]            now_reg, now_next;
    logic [31:0]            next_seq_reg, next_seq_next;
    logic [15:0]            tick_reg;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_word_reg, m_word_next;
    entry_t                 rd_data_reg;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    out_word_t              out_word;
    logic                   mem_we;
    logic [IdxW-1:0]        mem_waddr;
    entry_t                 mem_wdata;
    logic [IdxW-1:0]        rd_addr;
    entry_t                 in_entry;
    logic [31:0]            in_seq;
    logic [31:0]            time_sum;
    logic                   scan_last;
    logic                   cand_due;
    logic                   cand_better;
    logic                   pick_move;
    logic                   copy_more;

    assign s_ready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    // Incoming event, with an assigned sequence when zero
    assign in_seq   = (s_word.sequence_in == 32'd0) ? next_seq_reg : s_word.sequence_in;
    assign in_entry = '{deadline: s_word.deadline_ms, seq: in_seq, kind: s_word.event_kind,
                        source: s_word.source_id, target: s_word.target_id,
                        data: s_word.payload};

    // Saturating tick add
    assign time_sum = {1'b0, now_reg} + {16'd0, tick_reg};

    // Scan compare: due and strictly smaller key keeps the earliest on ties
    assign cand_due    = rd_data_reg.deadline <= now_reg;
    assign cand_better = !best_found_reg ||
                         ({rd_data_reg.deadline, rd_data_reg.seq} <
                          {best_reg.deadline, best_reg.seq});
    assign scan_last   = (CntW'(idx_reg) + CntW'(1)) == used_reg;
    assign pick_move   = (CntW'(best_idx_reg) + CntW'(1)) < used_reg;
    assign copy_more   = (CntW'(idx_reg) + CntW'(1)) < used_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_word.mode == MODE_RELEASE) begin
                    state_next = (used_reg == '0) ? S_PICK : S_SCAN_RD;
                end
            end
            S_SCAN_RD: state_next = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (scan_last) begin
                    state_next = S_PICK;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_PICK: begin
                if (!best_found_reg) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else if (!pend_valid_reg || out_free) begin
                    state_next = pick_move ? S_COPY_RD : S_NEXT;
                end
            end
            S_COPY_RD: state_next = S_COPY_WR;
            S_COPY_WR: begin
                if (copy_more) begin
                    state_next = S_COPY_RD;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (rel_cnt_reg == REL_CNT_W'(MAX_RELEASE)) begin
                    state_next = S_FINAL;
                end else if (used_reg == '0) begin
                    state_next = S_PICK;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        used_next       = used_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        best_next       = best_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rel_cnt_next    = rel_cnt_reg;
        now_next        = now_reg;
        next_seq_next   = next_seq_reg;
        out_load        = 1'b0;
        out_word        = m_word_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;
        rd_addr         = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_word.mode)
                        MODE_SCHEDULE: begin
                            if (s_word.sequence_in == 32'd0) begin
                                next_seq_next = next_seq_reg + 32'd1;
                            end
                            out_load = 1'b1;
                            if (used_reg < CntW'(QUEUE_DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = used_reg[IdxW-1:0];
                                mem_wdata = in_entry;
                                used_next = used_reg + CntW'(1);
                                out_word  = make_result(STAT_SCHEDULED, in_entry,
                                                        now_reg, 1'b1);
                            end else begin
                                out_word  = make_result(STAT_DROPPED, in_entry,
                                                        now_reg, 1'b1);
                            end
                        end
                        MODE_ADVANCE: begin
                            now_next = time_sum[31] ? TIME_MAX : time_sum[30:0];
                            out_load = 1'b1;
                            out_word = make_result(STAT_ADVANCED, '0, now_next, 1'b1);
                        end
                        MODE_RELEASE: begin
                            idx_next        = '0;
                            best_found_next = 1'b0;
                            rel_cnt_next    = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD: rd_addr = idx_reg;
            S_SCAN_CMP: begin
                if (cand_due && cand_better) begin
                    best_next       = rd_data_reg;
                    best_idx_next   = idx_reg;
                    best_found_next = 1'b1;
                end
                if (!scan_last) begin
                    idx_next = idx_reg + IdxW'(1);
                end
            end
            S_PICK: begin
                if (!best_found_reg) begin
                    // no more due events: close the release word
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_word        = pend_valid_reg
                                        ? make_result(STAT_RELEASED, pend_reg, now_reg, 1'b1)
                                        : make_result(STAT_NONE_DUE, '0, now_reg, 1'b1);
                        pend_valid_next = 1'b0;
                    end
                end else if (!pend_valid_reg || out_free) begin
                    // more follows, so the held event is not the last
                    if (pend_valid_reg) begin
                        out_load = 1'b1;
                        out_word = make_result(STAT_RELEASED, pend_reg, now_reg, 1'b0);
                    end
                    pend_next       = best_reg;
                    pend_valid_next = 1'b1;
                    rel_cnt_next    = rel_cnt_reg + REL_CNT_W'(1);
                    used_next       = used_reg - CntW'(1);
                    idx_next        = best_idx_reg;
                end
            end
            S_COPY_RD: rd_addr = idx_reg + IdxW'(1);
            S_COPY_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                idx_next  = idx_reg + IdxW'(1);
            end
            S_NEXT: begin
                idx_next        = '0;
                best_found_next = 1'b0;
            end
            S_FINAL: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_word        = make_result(STAT_RELEASED, pend_reg, now_reg, 1'b1);
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase

        // Output register
        if (out_load) begin
            m_valid_next = 1'b1;
            m_word_next  = out_word;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_word_next  = m_word_reg;
        end
    end

    // Slot memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rel_cnt_reg    <= '0;
            now_reg        <= '0;
            next_seq_reg   <= 32'd1;
            tick_reg       <= TICK_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            best_found_reg <= best_found_next;
            pend_valid_reg <= pend_valid_next;
            rel_cnt_reg    <= rel_cnt_next;
            now_reg        <= now_next;
            next_seq_reg   <= next_seq_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                tick_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        pend_reg     <= pend_next;
        m_word_reg   <= m_word_next;
    end

endmodule
